FILE: rtl/smac_pkg.sv
// ----------------------------------------------------------------------------
// smac_pkg
// Shared types, constants and helpers of the soil moisture averager.
// ----------------------------------------------------------------------------
package smac_pkg;

  localparam int RAW_W = 12;
  localparam int PCT_W = 15;
  localparam int LVL_W = 2;

  localparam int DIV_NUM_W = 27;
  localparam int DIV_QUO_W = 15;
  localparam int DIV_DEN_W = 12;

  localparam logic [RAW_W-1:0] LOW_LIMIT   = 12'd50;
  localparam logic [RAW_W-1:0] HIGH_LIMIT  = 12'd4000;
  localparam logic [RAW_W-1:0] DEFAULT_DRY = 12'd3000;
  localparam logic [RAW_W-1:0] DEFAULT_WET = 12'd1200;
  localparam logic [PCT_W-1:0] FULL_SCALE  = 15'd25600;
  localparam logic [PCT_W-1:0] DRY_BELOW   = 15'd7680;
  localparam logic [PCT_W-1:0] WET_ABOVE   = 15'd17920;

  localparam logic REG_DRY = 1'b0;
  localparam logic REG_WET = 1'b1;

  localparam logic [LVL_W-1:0] LVL_NONE    = 2'd0;
  localparam logic [LVL_W-1:0] LVL_DRY     = 2'd1;
  localparam logic [LVL_W-1:0] LVL_OPTIMAL = 2'd2;
  localparam logic [LVL_W-1:0] LVL_WET     = 2'd3;

  typedef struct packed {
    logic [RAW_W-1:0] reading;
    logic             in_range;
  } smac_cmd_t;

  function automatic logic [LVL_W-1:0] classify(input logic [PCT_W-1:0] pct);
    logic [LVL_W-1:0] lvl;
    if (pct < DRY_BELOW) begin
      lvl = LVL_DRY;
    end else if (pct > WET_ABOVE) begin
      lvl = LVL_WET;
    end else begin
      lvl = LVL_OPTIMAL;
    end
    return lvl;
  endfunction

endpackage

FILE: rtl/smac_front.sv
// ----------------------------------------------------------------------------
// smac_front
// Input stage: takes one reading per transaction and tags it with its range
// check before handing it to the command queue.
// ----------------------------------------------------------------------------
module smac_front import smac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [11:0] reading
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output smac_cmd_t         cmd
);

  logic             fvalid;
  smac_cmd_t        fcmd;
  logic [RAW_W-1:0] rd;

  assign rd        = s_tdata[RAW_W-1:0];
  assign s_tready  = !fvalid || cmd_ready;
  assign cmd_valid = fvalid;
  assign cmd       = fcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (s_tready) begin
      fvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      fcmd.reading  <= rd;
      fcmd.in_range <= (rd > LOW_LIMIT) && (rd < HIGH_LIMIT);
    end
  end

endmodule

FILE: rtl/smac_queue.sv
// ----------------------------------------------------------------------------
// smac_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module smac_queue import smac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  smac_cmd_t in_cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output smac_cmd_t out_cmd
);

  smac_cmd_t   entry [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = entry[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= in_cmd;
    end
  end

endmodule

FILE: rtl/smac_div.sv
// ----------------------------------------------------------------------------
// smac_div
// Shared restoring divider, one quotient bit per cycle. The quotient must fit
// in DIV_QUO_W bits, so the remainder starts from the numerator's top bits.
// ----------------------------------------------------------------------------
module smac_div import smac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_QUO_W-1:0] quo
);

  logic                 busy;
  logic [4:0]           steps;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dsr;
  logic [DIV_QUO_W-1:0] nq;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign shifted = {rem, nq[DIV_QUO_W-1]};
  assign ge      = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};
  assign quo     = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= 5'd0;
    end else begin
      done <= busy && !start && (steps == 5'd1);
      if (start) begin
        busy  <= 1'b1;
        steps <= 5'(DIV_QUO_W);
      end else if (busy) begin
        steps <= steps - 5'd1;
        if (steps == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[DIV_NUM_W-1:DIV_QUO_W];
      nq  <= num[DIV_QUO_W-1:0];
      dsr <= den;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      nq  <= {nq[DIV_QUO_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/smac_back.sv
// ----------------------------------------------------------------------------
// smac_back
// Back part: keeps the sample ring and calibration, computes the mean and the
// percentage on the shared divider, and holds the result for the output.
// ----------------------------------------------------------------------------
module smac_back import smac_pkg::*; #(
  parameter int SAMPLE_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [RAW_W-1:0] cfg_data,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  smac_cmd_t        cmd,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata
);

  localparam int SLOT_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int SUM_W  = RAW_W + $clog2(SAMPLE_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_UPDATE    = 9'b000000010,
    S_AVG_START = 9'b000000100,
    S_AVG_WAIT  = 9'b000001000,
    S_SCALE     = 9'b000010000,
    S_MUL       = 9'b000100000,
    S_PCT_START = 9'b001000000,
    S_PCT_WAIT  = 9'b010000000,
    S_EMIT      = 9'b100000000
  } state_t;

  state_t state;

  logic [RAW_W-1:0]      dry_point;
  logic [RAW_W-1:0]      wet_point;
  logic [RAW_W-1:0]      ring [SAMPLE_DEPTH];
  logic [RAW_W-1:0]      ring_rdata;
  logic [SAMPLE_DEPTH-1:0] filled;
  logic [SLOT_W-1:0]     write_slot;
  logic [SUM_W-1:0]      ring_sum;
  logic [CNT_W-1:0]      filled_count;
  logic [RAW_W-1:0]      held_average;
  logic [PCT_W-1:0]      held_percent;
  logic                  last_valid;
  logic [RAW_W-1:0]      rd;
  logic [RAW_W-1:0]      old;
  logic [RAW_W-1:0]      span_num;
  logic [RAW_W-1:0]      span_den;
  logic [DIV_NUM_W-1:0]  prod;

  logic                  bad_cal;
  logic [RAW_W-1:0]      dry_eff;
  logic [RAW_W-1:0]      wet_eff;

  logic                  div_start;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_DEN_W-1:0]  div_den;
  logic                  div_done;
  logic [DIV_QUO_W-1:0]  div_quo;

  logic                  out_free;

  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign old       = filled[write_slot] ? ring_rdata : '0;

  assign bad_cal = dry_point <= wet_point;
  assign dry_eff = bad_cal ? DEFAULT_DRY : dry_point;
  assign wet_eff = bad_cal ? DEFAULT_WET : wet_point;

  assign div_start = (state == S_AVG_START) || (state == S_PCT_START);
  assign div_num   = (state == S_AVG_START) ?
                     {{(DIV_NUM_W-SUM_W){1'b0}}, ring_sum} : prod;
  assign div_den   = (state == S_AVG_START) ?
                     {{(DIV_DEN_W-CNT_W){1'b0}}, filled_count} : span_den;

  smac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    ring_rdata <= ring[write_slot];
    if (state == S_UPDATE) begin
      ring[write_slot] <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      dry_point    <= DEFAULT_DRY;
      wet_point    <= DEFAULT_WET;
      filled       <= '0;
      write_slot   <= '0;
      ring_sum     <= '0;
      filled_count <= '0;
      held_average <= '0;
      held_percent <= '0;
      last_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == REG_DRY) begin
          dry_point <= cfg_data;
        end else begin
          wet_point <= cfg_data;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            last_valid <= cmd.in_range;
            state      <= cmd.in_range ? S_UPDATE : S_EMIT;
          end
        end
        S_UPDATE: begin
          filled[write_slot] <= 1'b1;
          if (!filled[write_slot]) begin
            filled_count <= filled_count + CNT_W'(1);
          end
          ring_sum <= ring_sum - SUM_W'(old) + SUM_W'(rd);
          if (write_slot == SLOT_W'(SAMPLE_DEPTH - 1)) begin
            write_slot <= '0;
          end else begin
            write_slot <= write_slot + SLOT_W'(1);
          end
          state <= S_AVG_START;
        end
        S_AVG_START: begin
          state <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (div_done) begin
            held_average <= div_quo[RAW_W-1:0];
            state        <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (bad_cal && !cfg_we) begin
            dry_point <= DEFAULT_DRY;
            wet_point <= DEFAULT_WET;
          end
          span_num <= dry_eff - held_average;
          span_den <= dry_eff - wet_eff;
          if (held_average >= dry_eff) begin
            held_percent <= '0;
            state        <= S_EMIT;
          end else if (held_average <= wet_eff) begin
            held_percent <= FULL_SCALE;
            state        <= S_EMIT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_PCT_START;
        end
        S_PCT_START: begin
          state <= S_PCT_WAIT;
        end
        S_PCT_WAIT: begin
          if (div_done) begin
            held_percent <= div_quo;
            state        <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      rd <= cmd.reading;
    end
    if (state == S_MUL) begin
      prod <= DIV_NUM_W'(span_num) * DIV_NUM_W'(FULL_SCALE);
    end
    if (state == S_EMIT && out_free) begin
      m_tdata <= {2'b00,
                  last_valid ? classify(held_percent) : LVL_NONE,
                  held_percent,
                  held_average,
                  last_valid};
    end
  end

endmodule

FILE: rtl/soil_moisture_averager_classifier.sv
// Each accepted reading makes two passes through the shared divider, only one when
// its mean lies outside the calibration span, and a rejected reading makes none.
// The back part takes a new reading only once it has emitted the last result; the
// front stage and the two-entry queue hold readings that arrive in the meantime.
// Reset: synchronous; clears the ring fill flags, sum, count and held results and
// restores the calibration points to 3000 and 1200.
// ----------------------------------------------------------------------------
// soil_moisture_averager_classifier
// Moving average of soil readings with two-point calibration to a percentage
// and a dry/optimal/wet level.
// ----------------------------------------------------------------------------
module soil_moisture_averager_classifier import smac_pkg::*; #(
  parameter int SAMPLE_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [RAW_W-1:0] cfg_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // [11:0] reading
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata    // [0] accepted, [12:1] average_raw,
                                      // [27:13] moisture_pct, [29:28] level
);

  logic      f_valid;
  logic      f_ready;
  smac_cmd_t f_cmd;
  logic      q_valid;
  logic      q_ready;
  smac_cmd_t q_cmd;

  smac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  smac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  smac_back #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the soil moisture averager: drives readings and
// calibration writes, predicts the ring average, percentage and level of
// every transaction and compares each result field by field.
// ----------------------------------------------------------------------------
module tb;
  import smac_pkg::*;

  localparam int DEPTH       = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic             accepted;
    logic [RAW_W-1:0] average;
    logic [PCT_W-1:0] percent;
    logic [LVL_W-1:0] level;
  } moisture_result_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = REG_DRY;
  logic [RAW_W-1:0] cfg_data  = '0;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata   = '0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [31:0]      m_tdata;

  // predictor state
  logic [RAW_W-1:0] ring_copy [DEPTH];
  int unsigned      ring_slot;
  int unsigned      ring_total;
  int unsigned      ring_filled;
  logic [RAW_W-1:0] avg_hold;
  logic [PCT_W-1:0] pct_hold;
  logic [RAW_W-1:0] cal_dry;
  logic [RAW_W-1:0] cal_wet;

  moisture_result_t expected_moisture[$];

  bit          src_idle_on = 1'b1;
  bit          snk_idle_on = 1'b1;
  int unsigned error_count;
  int unsigned readings_sent;
  int unsigned readings_in_range;
  int unsigned cal_writes;
  int unsigned level_seen [4];
  int unsigned quiet_cycles;
  int unsigned phase_center;

  soil_moisture_averager_classifier #(.SAMPLE_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic compute_moisture(input logic [RAW_W-1:0] value);
    moisture_result_t res;
    int unsigned      span;
    res = '0;
    readings_sent++;
    if (value > LOW_LIMIT && value < HIGH_LIMIT) begin
      readings_in_range++;
      if (ring_copy[ring_slot] == '0) begin
        ring_filled++;
      end
      ring_total = ring_total - ring_copy[ring_slot] + value;
      ring_copy[ring_slot] = value;
      ring_slot = (ring_slot + 1) % DEPTH;
      avg_hold = RAW_W'(ring_total / ring_filled);
      // fall back to the default points on a bad calibration
      if (cal_dry <= cal_wet) begin
        cal_dry = DEFAULT_DRY;
        cal_wet = DEFAULT_WET;
      end
      if (avg_hold >= cal_dry) begin
        pct_hold = '0;
      end else if (avg_hold <= cal_wet) begin
        pct_hold = FULL_SCALE;
      end else begin
        span = int'(cal_dry) - int'(cal_wet);
        pct_hold = PCT_W'(((int'(cal_dry) - int'(avg_hold)) * 25600) / span);
      end
      res.accepted = 1'b1;
      if (pct_hold < DRY_BELOW) begin
        res.level = LVL_DRY;
      end else if (pct_hold > WET_ABOVE) begin
        res.level = LVL_WET;
      end else begin
        res.level = LVL_OPTIMAL;
      end
    end else begin
      res.level = LVL_NONE;
    end
    res.average = avg_hold;
    res.percent = pct_hold;
    expected_moisture.push_back(res);
  endtask

  task automatic send_reading(input logic [RAW_W-1:0] value);
    while (src_idle_on && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    compute_moisture(value);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_moisture.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_calibration(input logic idx, input logic [RAW_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DRY) begin
      cal_dry = value;
    end else begin
      cal_wet = value;
    end
    cal_writes++;
    @(posedge clk);
  endtask

  task automatic set_calibration(input logic [RAW_W-1:0] dry, input logic [RAW_W-1:0] wet);
    wait_for_results();
    write_calibration(REG_DRY, dry);
    write_calibration(REG_WET, wet);
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    error_count++;
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : result_check
    moisture_result_t want;
    m_tready <= snk_idle_on ? ($urandom_range(99) >= 12) : 1'b1;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_moisture.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 1);
        end else begin
          want = expected_moisture.pop_front();
          level_seen[want.level]++;
          if (m_tdata[0] !== want.accepted)
            report_mismatch("accepted", want.accepted, m_tdata[0]);
          if (m_tdata[12:1] !== want.average)
            report_mismatch("average_raw", want.average, m_tdata[12:1]);
          if (m_tdata[27:13] !== want.percent)
            report_mismatch("moisture_pct", want.percent, m_tdata[27:13]);
          if (m_tdata[29:28] !== want.level)
            report_mismatch("level", want.level, m_tdata[29:28]);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // rejects before any data, then both edges of the accepted window
  task automatic test_range_limits();
    send_reading(12'd0);
    send_reading(12'd50);
    send_reading(12'd4000);
    send_reading(12'd4095);
    send_reading(12'd51);
    send_reading(12'd3999);
    send_reading(12'd4000);
  endtask

  // overwrite the oldest slot once the ring is full
  task automatic test_ring_wrap();
    repeat (7) send_reading(12'd3999);
  endtask

  // ring holds 3999 everywhere; move the points around it
  task automatic test_calibration_points();
    set_calibration(12'd4002, 12'd3992);
    send_reading(12'd3999);
    set_calibration(12'd4006, 12'd3996);
    send_reading(12'd3999);
    set_calibration(12'd3999, 12'd0);
    send_reading(12'd3999);
    set_calibration(12'd4095, 12'd3999);
    send_reading(12'd3999);
    set_calibration(12'd1000, 12'd1000);
    send_reading(12'd3999);
    set_calibration(12'd0, 12'd4095);
    send_reading(12'd3999);
    set_calibration(12'd4095, 12'd0);
    send_reading(12'd3999);
  endtask

  function automatic logic [RAW_W-1:0] pick_reading();
    int unsigned pick;
    int          v;
    pick = $urandom_range(19);
    case (pick)
      0: v = $urandom_range(50);
      1: v = $urandom_range(4095, 4000);
      2: begin
        case ($urandom_range(3))
          0: v = 50;
          1: v = 51;
          2: v = 3999;
          default: v = 4000;
        endcase
      end
      3, 4, 5, 6, 7, 8, 9, 10, 11: begin
        v = int'(phase_center) + int'($urandom_range(300)) - 150;
        if (v < 51) v = 51;
        if (v > 3999) v = 3999;
      end
      default: v = $urandom_range(3999, 51);
    endcase
    return RAW_W'(v);
  endfunction

  task automatic pick_calibration();
    int unsigned wet;
    case ($urandom_range(9))
      0: set_calibration(12'd4095, 12'd0);
      1: set_calibration(RAW_W'($urandom_range(2000)), RAW_W'($urandom_range(4095, 2000)));
      2: begin
        wet = $urandom_range(4095);
        set_calibration(RAW_W'(wet), RAW_W'(wet));
      end
      3: begin
        wait_for_results();
        write_calibration(REG_WET, RAW_W'($urandom_range(1500, 500)));
      end
      default: begin
        wet = $urandom_range(3000);
        set_calibration(RAW_W'($urandom_range(4095, wet + 1)), RAW_W'(wet));
      end
    endcase
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      pick_calibration();
      phase_center = (cal_dry > cal_wet) ? $urandom_range(cal_dry, cal_wet)
                                         : $urandom_range(3999, 51);
      src_idle_on = (phase != 3);
      snk_idle_on = (phase != 3);
      for (int n = 0; n < 48; n++) begin
        send_reading(pick_reading());
        if ($urandom_range(49) == 0) begin
          wait_for_results();
        end
      end
    end
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) ring_copy[i] = '0;
    ring_slot   = 0;
    ring_total  = 0;
    ring_filled = 0;
    avg_hold    = '0;
    pct_hold    = '0;
    cal_dry     = DEFAULT_DRY;
    cal_wet     = DEFAULT_WET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_range_limits();
    test_ring_wrap();
    test_calibration_points();
    test_random_traffic();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d readings (%0d in range) over %0d calibration writes",
             readings_sent, readings_in_range, cal_writes);
    $display("levels checked: none %0d, dry %0d, optimal %0d, wet %0d",
             level_seen[0], level_seen[1], level_seen[2], level_seen[3]);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
